// ===== rtl/wfb_pkg.sv =====
// Package for the word frame builder: byte counts, register map,
// reset values and the item type passed from the input stage to the serializer.
// No dependencies.
package wfb_pkg;

   localparam int BYTES_MAX = 7;
   localparam int CNT_W     = 3;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam logic [7:0] SYNC_RESET = 8'hAA;

   localparam logic REG_SYNC_BYTE = 1'b0;

   localparam logic [CNT_W-1:0] CNT_WORD     = 3'd4;
   localparam logic [CNT_W-1:0] CNT_SYNC     = 3'd1;
   localparam logic [CNT_W-1:0] CNT_CHECKSUM = 3'd2;
   localparam logic [CNT_W-1:0] CNT_ONE      = 3'd1;

   typedef logic [BYTES_MAX-1:0][7:0] byte_vec_type;

   typedef struct packed {
      byte_vec_type      bytes;
      logic [CNT_W-1:0]  count;
      logic              closes;
   } item_type;

endpackage

// ===== rtl/wfb_req_if.sv =====
// Input channel of the word frame builder: one word and its last-of-frame flag.
// No dependencies.
interface wfb_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] value_bits;
   logic        last_value;

   modport source (output valid, output value_bits, output last_value, input ready);
   modport sink   (input valid, input value_bits, input last_value, output ready);
endinterface

// ===== rtl/wfb_rsp_if.sv =====
// Result channel of the word frame builder: one frame byte and its end marks.
// No dependencies.
interface wfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;
   logic       frame_end;

   modport source (output valid, output out_byte, output run_end, output frame_end,
                   input ready);
   modport sink   (input valid, input out_byte, input run_end, input frame_end,
                   output ready);
endinterface

// ===== rtl/wfb_serializer.sv =====
// Byte serializer: holds the bytes of one input transaction and shifts them out.
// Depends on wfb_pkg and wfb_rsp_if.
module wfb_serializer (
   input  logic               clock,
   input  logic               reset,
   input  logic               load_valid,
   input  wfb_pkg::item_type  load_item,
   output logic               load_ready,
   wfb_rsp_if.source          rsp_bus
);

   wfb_pkg::byte_vec_type           bytes_ff, bytes_in;
   logic [wfb_pkg::CNT_W-1:0]       rem_ff, rem_in;
   logic                            closes_ff, closes_in;
   logic                            take;
   logic                            final_byte;
   logic                            load;

   assign final_byte = (rem_ff == wfb_pkg::CNT_ONE);
   assign take       = rsp_bus.valid && rsp_bus.ready;
   assign load_ready = (rem_ff == '0) || (take && final_byte);
   assign load       = load_valid && load_ready;

   assign rsp_bus.valid     = (rem_ff != '0);
   assign rsp_bus.out_byte  = bytes_ff[0];
   assign rsp_bus.run_end   = final_byte;
   assign rsp_bus.frame_end = final_byte && closes_ff;

   always_comb begin
      bytes_in  = bytes_ff;
      rem_in    = rem_ff;
      closes_in = closes_ff;
      if (load) begin
         bytes_in  = load_item.bytes;
         rem_in    = load_item.count;
         closes_in = load_item.closes;
      end else if (take) begin
         bytes_in = {8'h00, bytes_ff[wfb_pkg::BYTES_MAX-1:1]};
         rem_in   = rem_ff - wfb_pkg::CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
      bytes_ff  <= bytes_in;
      closes_ff <= closes_in;
   end

endmodule

// ===== rtl/word_frame_builder_sum16.sv =====
// Word frame builder with sync byte and 16-bit additive checksum, top level.
// Depends on wfb_pkg, wfb_req_if, wfb_rsp_if and wfb_serializer.
//
//   channel   direction  width of payload          transfer
//   req_bus   in         value_bits 32, last 1     valid && ready
//   rsp_bus   out        byte 8, run_end, frame    valid && ready
//   apb csr   in/out     sync_byte 8 at offset 0   psel && penable && pwrite
//
// Each word leaves the serializer as 4 to 7 bytes, one per cycle while
// rsp_bus.ready is high: 4 word bytes, 1 sync byte at start, 2 checksum at close.
// An input stage holds the next word's bytes, so req_bus is taken while
// bytes still drain; req_bus.ready is low only while that stage is full.
// Reset is synchronous: empty stages, no frame open, checksum zero, sync 0xAA.
module word_frame_builder_sum16 (
   input  logic                          clock,
   input  logic                          reset,
   wfb_req_if.sink                       req_bus,
   wfb_rsp_if.source                     rsp_bus,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [wfb_pkg::ADDR_W-1:0]    paddr,
   input  logic [wfb_pkg::DATA_W-1:0]    pwdata,
   output logic [wfb_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   logic [7:0]           sync_ff, sync_in;
   logic [15:0]          sum_ff, sum_in;
   logic                 in_frame_ff, in_frame_in;
   logic                 a_valid_ff, a_valid_in;
   wfb_pkg::item_type    a_item_ff, a_item_in;
   logic                 accept;
   logic                 load_ready;
   logic                 csr_write;
   logic [15:0]          base_sum;
   logic [15:0]          new_sum;
   logic [31:0]          w;
   logic [7:0]           b [7];

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == wfb_pkg::REG_SYNC_BYTE) ? {24'h0, sync_ff} : '0;

   assign sync_in = (csr_write && (paddr[2] == wfb_pkg::REG_SYNC_BYTE))
                    ? pwdata[7:0] : sync_ff;

   assign req_bus.ready = !a_valid_ff;
   assign accept        = req_bus.valid && req_bus.ready;
   assign w             = req_bus.value_bits;

   assign base_sum = in_frame_ff ? sum_ff : 16'h0000;
   assign new_sum  = base_sum + w[15:0] + w[31:16];

   always_comb begin
      b[0] = sync_ff;
      b[1] = w[7:0];
      b[2] = w[15:8];
      b[3] = w[23:16];
      b[4] = w[31:24];
      b[5] = new_sum[7:0];
      b[6] = new_sum[15:8];
      a_item_in = a_item_ff;
      if (accept) begin
         for (int i = 0; i < wfb_pkg::BYTES_MAX; i++) begin
            a_item_in.bytes[i] = 8'h00;
         end
         if (in_frame_ff) begin
            for (int i = 0; i < wfb_pkg::BYTES_MAX - 1; i++) begin
               a_item_in.bytes[i] = b[i + 1];
            end
         end else begin
            for (int i = 0; i < wfb_pkg::BYTES_MAX; i++) begin
               a_item_in.bytes[i] = b[i];
            end
         end
         a_item_in.count = wfb_pkg::CNT_WORD
                         + (in_frame_ff ? '0 : wfb_pkg::CNT_SYNC)
                         + (req_bus.last_value ? wfb_pkg::CNT_CHECKSUM : '0);
         a_item_in.closes = req_bus.last_value;
      end
   end

   always_comb begin
      sum_in      = sum_ff;
      in_frame_in = in_frame_ff;
      if (accept) begin
         if (req_bus.last_value) begin
            sum_in      = 16'h0000;
            in_frame_in = 1'b0;
         end else begin
            sum_in      = new_sum;
            in_frame_in = 1'b1;
         end
      end
   end

   assign a_valid_in = a_valid_ff ? !load_ready : accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff     <= wfb_pkg::SYNC_RESET;
         sum_ff      <= 16'h0000;
         in_frame_ff <= 1'b0;
         a_valid_ff  <= 1'b0;
      end else begin
         sync_ff     <= sync_in;
         sum_ff      <= sum_in;
         in_frame_ff <= in_frame_in;
         a_valid_ff  <= a_valid_in;
      end
      a_item_ff <= a_item_in;
   end

   wfb_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load_valid (a_valid_ff),
      .load_item  (a_item_ff),
      .load_ready (load_ready),
      .rsp_bus    (rsp_bus)
   );

`ifndef SYNTHESIS
   a_frame_end_is_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.frame_end |-> rsp_bus.run_end)
      else $error("frame_end without run_end");

   a_sum_clear_outside_frame: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (sum_ff == 16'h0000))
      else $error("checksum not cleared between frames");

   a_drain_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && rsp_bus.run_end && !a_valid_ff |=> !rsp_bus.valid)
      else $error("serializer shows bytes with nothing loaded");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> a_valid_ff && !req_bus.ready)
      else $error("accepted word not held in input stage");
`endif

endmodule
